// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Clock and reset names follow the project convention: clock, reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK_RST(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/dbpv_pkg.sv =====
// Package for the drag-box polygon vertex generator.
// Sine polynomial constants, phase constants, sequencer states and flag types.
`default_nettype none

package dbpv_pkg;

   localparam int PHASE_W = 16;
   localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;
   localparam int DIV_W = 17;
   localparam logic [DIV_W-1:0] FULL_TURN = 17'h10000;
   localparam int MIN_SIDES = 3;
   localparam int SINE_LAST = 7;
   localparam int SINE_W = 30;

   localparam logic signed [31:0] K1  = 32'sd1686629713;
   localparam logic signed [31:0] K3  = 32'sd693598668;
   localparam logic signed [31:0] K5  = 32'sd85569306;
   localparam logic signed [31:0] K7  = 32'sd5026995;
   localparam logic signed [31:0] K9  = 32'sd172272;
   localparam logic signed [31:0] K11 = 32'sd3864;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SINE,
      ST_XMUL,
      ST_YMUL,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic from_center;
      logic square;
   } req_flags_type;

endpackage

`default_nettype wire

// ===== rtl/dbpv_front.sv =====
// Front stage: takes a drag beat and forms the doubled center and box size.
// Depends on dbpv_pkg for the flag type.
`default_nettype none

module dbpv_front import dbpv_pkg::*; #(
   parameter int COORD_WIDTH = 24
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic [4*COORD_WIDTH-1:0]   in_data,
   input  wire req_flags_type              in_flags,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic [4*COORD_WIDTH+6:0]        out_entry
);

   localparam int CW = COORD_WIDTH;

   logic signed [CW-1:0] sx, sy, ex, ey;
   logic signed [CW:0]   dx, dy, ddx, ddy;
   logic [CW:0]          adx_f, ady_f;
   logic [CW-1:0]        adx, ady, side, mx, my;
   logic signed [CW+1:0] cx2, cy2;
   logic [CW:0]          w, h;
   logic                 empty;
   logic                 val_ff, val_in;
   logic [4*CW+6:0]      entry_ff, entry_in;

   always_comb begin
      sx = $signed(in_data[CW-1:0]);
      sy = $signed(in_data[2*CW-1:CW]);
      ex = $signed(in_data[3*CW-1:2*CW]);
      ey = $signed(in_data[4*CW-1:3*CW]);
      dx = {ex[CW-1], ex} - {sx[CW-1], sx};
      dy = {ey[CW-1], ey} - {sy[CW-1], sy};
      adx_f = dx[CW] ? -dx : dx;
      ady_f = dy[CW] ? -dy : dy;
      adx = adx_f[CW-1:0];
      ady = ady_f[CW-1:0];
      side = (adx > ady) ? adx : ady;
      mx = in_flags.square ? side : adx;
      my = in_flags.square ? side : ady;
      ddx = in_flags.square ? (dx[CW] ? -$signed({1'b0, side}) : $signed({1'b0, side})) : dx;
      ddy = in_flags.square ? (dy[CW] ? -$signed({1'b0, side}) : $signed({1'b0, side})) : dy;
      if (in_flags.from_center) begin
         cx2 = {sx[CW-1], sx, 1'b0};
         cy2 = {sy[CW-1], sy, 1'b0};
         w = {mx, 1'b0};
         h = {my, 1'b0};
      end else begin
         cx2 = {sx[CW-1], sx, 1'b0} + {ddx[CW], ddx};
         cy2 = {sy[CW-1], sy, 1'b0} + {ddy[CW], ddy};
         w = {1'b0, mx};
         h = {1'b0, my};
      end
      empty = (mx == '0) || (my == '0);
   end

   assign in_ready  = !val_ff || out_ready;
   assign out_valid = val_ff;
   assign out_entry = entry_ff;

   always_comb begin
      val_in = val_ff;
      entry_in = entry_ff;
      if (in_valid && in_ready) begin
         val_in = 1'b1;
         entry_in = {empty, h, w, cy2, cx2};
      end else if (out_ready) begin
         val_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= 1'b0;
      end else begin
         val_ff <= val_in;
      end
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ===== rtl/dbpv_fifo.sv =====
// Short register queue between the front and back stages.
// Standalone; width and depth set by parameters, depth a power of two.
`default_nettype none

module dbpv_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_valid,
   output logic                  wr_ready,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  rd_valid,
   input  wire logic             rd_ready,
   output logic [WIDTH-1:0]      rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   assign wr_ready = cnt_ff != CNT_W'(DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data  = mem_ff[rp_ff];
   assign push = wr_valid && wr_ready;
   assign pop  = rd_valid && rd_ready;

   always_comb begin
      wp_in = push ? AW'(wp_ff + 1'b1) : wp_ff;
      rp_in = pop ? AW'(rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dbpv_back.sv =====
// Back stage: per-box sequencer that divides out the phase step, runs two
// sine evaluations per vertex on one shared multiplier and emits the beats.
// Depends on dbpv_pkg for constants and the state type.
`default_nettype none

module dbpv_back import dbpv_pkg::*; #(
   parameter int COORD_WIDTH = 24,
   parameter int MAX_SIDES = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [6:0]               sides,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [4*COORD_WIDTH+6:0] in_entry,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [COORD_WIDTH-1:0]        out_x,
   output logic [COORD_WIDTH-1:0]        out_y,
   output logic [5:0]                    out_index,
   output logic                          out_empty,
   output logic                          out_last
);

   localparam int CW = COORD_WIDTH;
   localparam int NW = $clog2(MAX_SIDES + 1);
   localparam int CMP_W = (NW > 7) ? NW : 7;
   localparam int MW = (CW + 2 > 32) ? CW + 2 : 32;
   localparam int PW = 2 * MW;
   localparam logic signed [PW-1:0] CMAX = $signed((PW'(1) << (CW - 1)) - PW'(1));
   localparam logic signed [PW-1:0] CMIN = -CMAX - PW'(1);

   back_state_type state_ff, state_in;

   logic signed [CW+1:0] e_cx2, e_cy2, cx2_ff, cy2_ff, cx2_in, cy2_in;
   logic [CW:0]          e_w, e_h, w_ff, h_ff, w_in, h_in;
   logic                 e_empty;

   logic [NW-1:0]        n_ff, n_in, i_ff, i_in, rem_ff, rem_in, ar_ff, ar_in;
   logic [NW-1:0]        n_clamp;
   logic [CMP_W-1:0]     sides_c;
   logic [DIV_W-1:0]     quo_ff, quo_in, dv_ff, dv_in;
   logic [4:0]           dcnt_ff, dcnt_in;
   logic [PHASE_W-1:0]   p_ff, p_in, ph;
   logic                 which_ff, which_in;
   logic [2:0]           ss_ff, ss_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [MW-1:0] x2_ff, x2_in;
   logic signed [SINE_W-1:0] s_ff, s_in, c_ff, c_in, sres;
   logic [CW-1:0]        vx_ff, vx_in;

   logic                 ov_ff, ov_in, oe_ff, oe_in, ol_ff, ol_in;
   logic [CW-1:0]        ox_ff, ox_in, oy_ff, oy_in;
   logic [5:0]           oi_ff, oi_in;

   logic                 out_free, pop, div_done, sine_done, last_v, ld_out;
   logic [NW:0]          dt, ar_sum;
   logic                 dge, age;
   logic [14:0]          rr;
   logic                 sneg;
   logic signed [31:0]   kc;
   logic signed [PW-1:0] t_w, mh, m2;
   logic signed [MW-1:0] mul_a, mul_b;
   logic                 mul_en;
   logic signed [PW-1:0] base, csum, crnd;
   logic [CW-1:0]        coord;

   assign {e_empty, e_h, e_w, e_cy2, e_cx2} = in_entry;

   assign out_free  = !ov_ff || out_ready;
   assign pop       = (state_ff == ST_IDLE) && in_valid && (!e_empty || out_free);
   assign in_ready  = pop;
   assign div_done  = dcnt_ff == 5'(DIV_W - 1);
   assign sine_done = ss_ff == 3'(SINE_LAST);
   assign last_v    = ({1'b0, i_ff} + 1'b1) == {1'b0, n_ff};

   assign out_valid = ov_ff;
   assign out_x     = ox_ff;
   assign out_y     = oy_ff;
   assign out_index = oi_ff;
   assign out_empty = oe_ff;
   assign out_last  = ol_ff;

   always_comb begin
      sides_c = CMP_W'(sides);
      if (sides_c < CMP_W'(MIN_SIDES)) begin
         n_clamp = NW'(MIN_SIDES);
      end else if (sides_c > CMP_W'(MAX_SIDES)) begin
         n_clamp = NW'(MAX_SIDES);
      end else begin
         n_clamp = NW'(sides_c);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop && !e_empty) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_SINE;
            end
         end
         ST_SINE: begin
            if (sine_done && which_ff) begin
               state_in = ST_XMUL;
            end
         end
         ST_XMUL: state_in = ST_YMUL;
         ST_YMUL: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = last_v ? ST_IDLE : ST_SINE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Quarter-wave folding, Horner coefficients, coordinate rounding and clamping, divider and remainder compares
   always_comb begin
      ph = which_ff ? PHASE_W'(p_ff + QUARTER_TURN) : p_ff;
      rr = ph[14] ? (15'h4000 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
      sneg = ph[15];
      case (ss_ff)
         3'd2:    kc = K9;
         3'd3:    kc = K7;
         3'd4:    kc = K5;
         3'd5:    kc = K3;
         3'd6:    kc = K1;
         default: kc = K11;
      endcase
      t_w = PW'(kc) - (prod_ff >>> 30);
      mh = (prod_ff >>> 14) + PW'(2);
      m2 = mh >>> 2;
      sres = sneg ? -$signed(m2[SINE_W-1:0]) : $signed(m2[SINE_W-1:0]);

      base = PW'((state_ff == ST_YMUL) ? cx2_ff : cy2_ff) <<< 28;
      csum = (state_ff == ST_YMUL) ? base + prod_ff : base - prod_ff;
      crnd = (csum + (PW'(1) <<< 28)) >>> 29;
      if (crnd > CMAX) begin
         coord = CMAX[CW-1:0];
      end else if (crnd < CMIN) begin
         coord = CMIN[CW-1:0];
      end else begin
         coord = crnd[CW-1:0];
      end

      dt = {rem_ff, dv_ff[DIV_W-1]};
      dge = dt >= {1'b0, n_ff};
      ar_sum = {1'b0, ar_ff} + {1'b0, rem_ff};
      age = ar_sum >= {1'b0, n_ff};
   end

   // Multiplier operand select
   always_comb begin
      mul_en = 1'b0;
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SINE: begin
            mul_en = !sine_done;
            case (ss_ff)
               3'd0: begin
                  mul_a = $signed(MW'(rr));
                  mul_b = $signed(MW'(rr));
               end
               3'd1: begin
                  mul_a = $signed({prod_ff[MW-3:0], 2'b00});
                  mul_b = MW'(K11);
               end
               3'd6: begin
                  mul_a = $signed(MW'(rr));
                  mul_b = $signed(t_w[MW-1:0]);
               end
               default: begin
                  mul_a = x2_ff;
                  mul_b = $signed(t_w[MW-1:0]);
               end
            endcase
         end
         ST_XMUL: begin
            mul_en = 1'b1;
            mul_a = $signed(MW'(w_ff));
            mul_b = MW'(s_ff);
         end
         ST_YMUL: begin
            mul_en = 1'b1;
            mul_a = $signed(MW'(h_ff));
            mul_b = MW'(c_ff);
         end
         default: mul_en = 1'b0;
      endcase
      prod_in = mul_en ? PW'(mul_a * mul_b) : prod_ff;
   end

   // Datapath and output register
   always_comb begin
      cx2_in = cx2_ff;
      cy2_in = cy2_ff;
      w_in = w_ff;
      h_in = h_ff;
      n_in = n_ff;
      i_in = i_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dv_in = dv_ff;
      dcnt_in = dcnt_ff;
      p_in = p_ff;
      ar_in = ar_ff;
      which_in = which_ff;
      ss_in = ss_ff;
      x2_in = x2_ff;
      s_in = s_ff;
      c_in = c_ff;
      vx_in = vx_ff;
      ld_out = 1'b0;
      ox_in = ox_ff;
      oy_in = oy_ff;
      oi_in = oi_ff;
      oe_in = oe_ff;
      ol_in = ol_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               if (e_empty) begin
                  ld_out = 1'b1;
                  ox_in = '0;
                  oy_in = '0;
                  oi_in = '0;
                  oe_in = 1'b1;
                  ol_in = 1'b1;
               end else begin
                  cx2_in = e_cx2;
                  cy2_in = e_cy2;
                  w_in = e_w;
                  h_in = e_h;
                  n_in = n_clamp;
                  rem_in = '0;
                  quo_in = '0;
                  dv_in = FULL_TURN;
                  dcnt_in = '0;
               end
            end
         end
         ST_DIV: begin
            rem_in = dge ? NW'(dt - {1'b0, n_ff}) : NW'(dt);
            quo_in = {quo_ff[DIV_W-2:0], dge};
            dv_in = {dv_ff[DIV_W-2:0], 1'b0};
            dcnt_in = dcnt_ff + 1'b1;
            if (div_done) begin
               p_in = '0;
               ar_in = n_ff >> 1;
               i_in = '0;
               which_in = 1'b0;
               ss_in = '0;
            end
         end
         ST_SINE: begin
            ss_in = ss_ff + 1'b1;
            if (ss_ff == 3'd1) begin
               x2_in = $signed({prod_ff[MW-3:0], 2'b00});
            end
            if (sine_done) begin
               if (which_ff) begin
                  c_in = sres;
               end else begin
                  s_in = sres;
               end
               which_in = !which_ff;
               ss_in = '0;
            end
         end
         ST_YMUL: vx_in = coord;
         ST_EMIT: begin
            if (out_free) begin
               ld_out = 1'b1;
               ox_in = vx_ff;
               oy_in = coord;
               oi_in = 6'(i_ff);
               oe_in = 1'b0;
               ol_in = last_v;
               i_in = i_ff + 1'b1;
               ar_in = age ? NW'(ar_sum - {1'b0, n_ff}) : NW'(ar_sum);
               p_in = p_ff + PHASE_W'(quo_ff) + PHASE_W'(age);
            end
         end
         default: ld_out = 1'b0;
      endcase
      ov_in = ld_out ? 1'b1 : (out_ready ? 1'b0 : ov_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff <= 1'b0;
         which_ff <= 1'b0;
         ss_ff <= '0;
         dcnt_ff <= '0;
         i_ff <= '0;
         n_ff <= NW'(MIN_SIDES);
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
         which_ff <= which_in;
         ss_ff <= ss_in;
         dcnt_ff <= dcnt_in;
         i_ff <= i_in;
         n_ff <= n_in;
      end
      cx2_ff <= cx2_in;
      cy2_ff <= cy2_in;
      w_ff <= w_in;
      h_ff <= h_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dv_ff <= dv_in;
      p_ff <= p_in;
      ar_ff <= ar_in;
      prod_ff <= prod_in;
      x2_ff <= x2_in;
      s_ff <= s_in;
      c_ff <= c_in;
      vx_ff <= vx_in;
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      oi_ff <= oi_in;
      oe_ff <= oe_in;
      ol_ff <= ol_in;
   end

endmodule

`default_nettype wire

// ===== rtl/drag_box_polygon_vertices.sv =====
// Top level of the drag-box polygon vertex generator.
// Instantiates dbpv_front, dbpv_fifo and dbpv_back; uses dbpv_pkg.
`default_nettype none

// One req beat is a drag (start, end, square and from-center flags); the block
// answers with one rsp beat per polygon vertex, tlast on the final one, or a
// single beat with tuser set when the box has zero width or height. The
// front stage registers the box and parks it in a two-entry queue, so up to
// three drags can be taken while the back stage works. Per drag the back
// stage takes the box and runs the phase-step division, then for each vertex
// two 8-step polynomial sine evaluations on its single shared multiplier,
// two coordinate products and the beat itself. A collapsed box skips the
// division and sine steps and gets its beat straight from the idle state.
// The side count is taken from csr_wr_data when csr_wr_en is high, reset 5.

module drag_box_polygon_vertices import dbpv_pkg::*; #(
   parameter int MAX_SIDES = 64,
   parameter int COORD_WIDTH = 24
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_tvalid,
   output logic                                          req_tready,
   // start_x, start_y, end_x, end_y
   input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0]       req_tdata,
   // square_constrain, from_center
   input  wire logic [1:0]                               req_tuser,
   output logic                                          rsp_tvalid,
   input  wire logic                                     rsp_tready,
   // vertex_x, vertex_y, vertex_index
   output logic [((2*COORD_WIDTH+6+7)/8)*8-1:0]          rsp_tdata,
   // empty_shape
   output logic                                          rsp_tuser,
   output logic                                          rsp_tlast,
   input  wire logic                                     csr_wr_en,
   input  wire logic [6:0]                               csr_wr_data
);

   localparam int CW = COORD_WIDTH;
   localparam int ENT_W = 4 * CW + 7;
   localparam int OUT_W = ((2 * CW + 6 + 7) / 8) * 8;

   logic [6:0]        sides_ff;
   req_flags_type     flags;
   logic              f_valid, f_ready, b_valid, b_ready;
   logic [ENT_W-1:0]  f_entry, b_entry;
   logic [CW-1:0]     vx, vy;
   logic [5:0]        vidx;

   assign flags = req_flags_type'(req_tuser);

   always_ff @(posedge clock) begin
      if (reset) begin
         sides_ff <= 7'd5;
      end else if (csr_wr_en) begin
         sides_ff <= csr_wr_data;
      end
   end

   dbpv_front #(.COORD_WIDTH(CW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata[4*CW-1:0]),
      .in_flags  (flags),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_entry (f_entry)
   );

   dbpv_fifo #(.WIDTH(ENT_W), .DEPTH(2)) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_data  (f_entry),
      .rd_valid (b_valid),
      .rd_ready (b_ready),
      .rd_data  (b_entry)
   );

   dbpv_back #(.COORD_WIDTH(CW), .MAX_SIDES(MAX_SIDES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .sides     (sides_ff),
      .in_valid  (b_valid),
      .in_ready  (b_ready),
      .in_entry  (b_entry),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (vx),
      .out_y     (vy),
      .out_index (vidx),
      .out_empty (rsp_tuser),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = OUT_W'({vidx, vy, vx});

endmodule

`default_nettype wire

// ===== rtl/dbpv_checker.sv =====
// Port-level checks for drag_box_polygon_vertices, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dbpv_checker #(
   parameter int COORD_WIDTH = 24
) (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  rsp_tvalid,
   input wire logic                                  rsp_tready,
   input wire logic [((2*COORD_WIDTH+6+7)/8)*8-1:0]  rsp_tdata,
   input wire logic                                  rsp_tuser,
   input wire logic                                  rsp_tlast
);

   `ASSERT_CLK_RST(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp beat changed while stalled")
   `ASSERT_CLK_RST(a_empty_last, rsp_tvalid && rsp_tuser |-> rsp_tlast, "empty beat without tlast")
   `ASSERT_CLK_RST(a_empty_zero, rsp_tvalid && rsp_tuser |-> rsp_tdata == '0, "empty beat carries data")
   `ASSERT_CLK(a_reset_quiet, reset |=> !rsp_tvalid, "rsp valid right after reset")

endmodule

bind drag_box_polygon_vertices dbpv_checker #(.COORD_WIDTH(COORD_WIDTH)) u_dbpv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== tb/sv/tb_drag_box_polygon_vertices.sv =====
// Self-checking testbench for drag_box_polygon_vertices: drives drag beats with
// random gaps and side-count changes, and predicts every vertex beat. Uses dbpv_pkg.
`timescale 1ns / 100ps

module tb_drag_box_polygon_vertices;
   import dbpv_pkg::*;

   localparam int CW = 24;
   localparam int SIDES_MAX = 64;
   localparam int SETTLE_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAG_TARGET = 410;
   localparam logic signed [CW-1:0] CMAX = 24'sh7FFFFF;
   localparam logic signed [CW-1:0] CMIN = 24'sh800000;
   localparam longint Q28 = 64'sd1 << 28;
   localparam longint K1L = 1686629713;
   localparam longint K3L = 693598668;
   localparam longint K5L = 85569306;
   localparam longint K7L = 5026995;
   localparam longint K9L = 172272;
   localparam longint K11L = 3864;

   typedef enum logic [1:0] {
      OP_DRAG,
      OP_SIDES,
      OP_QUIESCE
   } op_kind_type;

   typedef struct {
      op_kind_type kind;
      logic signed [CW-1:0] sx, sy, ex, ey;
      logic sq, fc;
      logic [6:0] sides;
   } stim_type;

   typedef struct {
      logic [CW-1:0] vx, vy;
      logic [5:0] idx;
      logic empty, last;
   } vertex_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   wire  req_tready;
   logic [95:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   wire  rsp_tvalid;
   logic rsp_tready = 0;
   wire  [55:0] rsp_tdata;
   wire  rsp_tuser;
   wire  rsp_tlast;
   logic csr_wr_en = 0;
   logic [6:0] csr_wr_data = '0;

   stim_type stim_q[$];
   vertex_type vertex_q[$];
   stim_type cur;
   logic [6:0] sides_reg = 7'd5;
   bit drv_done = 0;
   bit req_idle_on = 1, rsp_idle_on = 1;
   int gap = 0, stall = 0, settle = 0, watchdog = 0, errors = 0;
   int n_drags = 0, n_vertices = 0, n_empty = 0, n_sides_writes = 0;

   drag_box_polygon_vertices dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // sin over a quarter wave, r in [0, 16384], result Q28
   function automatic longint quarter_sin(longint r);
      longint x, x2, t;
      x = r << 16;
      x2 = (x * x) >>> 30;
      t = K11L;
      t = K9L - ((x2 * t) >>> 30);
      t = K7L - ((x2 * t) >>> 30);
      t = K5L - ((x2 * t) >>> 30);
      t = K3L - ((x2 * t) >>> 30);
      t = K1L - ((x2 * t) >>> 30);
      return (((x * t) >>> 30) + 2) >>> 2;
   endfunction

   function automatic longint phase_sin(int unsigned p);
      int unsigned q, r;
      longint m;
      p = p & 32'hFFFF;
      q = p >> 14;
      r = p & 32'h3FFF;
      m = q[0] ? quarter_sin(16384 - r) : quarter_sin(r);
      return q[1] ? -m : m;
   endfunction

   function automatic logic [CW-1:0] to_coord(longint v);
      longint r;
      r = (v + Q28) >>> 29;
      if (r > longint'(CMAX)) r = longint'(CMAX);
      if (r < longint'(CMIN)) r = longint'(CMIN);
      return r[CW-1:0];
   endfunction

   task automatic predict_vertices(stim_type s);
      longint sx, sy, dx, dy, side, cx2, cy2, w, h, sn, cs;
      int unsigned n, p;
      vertex_type v;
      sx = longint'(s.sx);
      sy = longint'(s.sy);
      dx = longint'(s.ex) - sx;
      dy = longint'(s.ey) - sy;
      if (s.sq) begin
         side = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                          : (dy < 0 ? -dy : dy);
         dx = dx < 0 ? -side : side;
         dy = dy < 0 ? -side : side;
      end
      if (s.fc) begin
         cx2 = 2 * sx;
         cy2 = 2 * sy;
         w = 2 * (dx < 0 ? -dx : dx);
         h = 2 * (dy < 0 ? -dy : dy);
      end else begin
         cx2 = 2 * sx + dx;
         cy2 = 2 * sy + dy;
         w = dx < 0 ? -dx : dx;
         h = dy < 0 ? -dy : dy;
      end
      if (w == 0 || h == 0) begin
         v = '{vx: '0, vy: '0, idx: '0, empty: 1'b1, last: 1'b1};
         vertex_q.insert(vertex_q.size(), v);
         n_empty++;
         return;
      end
      n = sides_reg < MIN_SIDES ? MIN_SIDES : (sides_reg > SIDES_MAX ? SIDES_MAX : sides_reg);
      for (int unsigned i = 0; i < n; i++) begin
         p = (i * 65536 + n / 2) / n;
         sn = phase_sin(p);
         cs = phase_sin(p + 16384);
         v.vx = to_coord(cx2 * Q28 + w * sn);
         v.vy = to_coord(cy2 * Q28 - h * cs);
         v.idx = i[5:0];
         v.empty = 1'b0;
         v.last = (i + 1 == n);
         vertex_q.insert(vertex_q.size(), v);
      end
   endtask

   function automatic int pick_gap(bit on);
      int r;
      r = $urandom_range(99);
      if (!on || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 50);
   endfunction

   // driver
   always @(posedge clock) begin
      logic wr;
      stim_type op;
      wr = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
         settle <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_vertices(cur);
            n_drags++;
         end
         if (req_tvalid && !req_tready) begin
         end else if (gap > 0) begin
            gap <= gap - 1;
            req_tvalid <= 1'b0;
         end else if (stim_q.size() == 0) begin
            req_tvalid <= 1'b0;
            drv_done <= 1'b1;
         end else if (stim_q[0].kind == OP_DRAG) begin
            cur = stim_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {cur.ey, cur.ex, cur.sy, cur.sx};
            req_tuser <= {cur.fc, cur.sq};
            gap <= pick_gap(req_idle_on);
         end else begin
            req_tvalid <= 1'b0;
            if (vertex_q.size() != 0) settle <= 0;
            else if (settle < SETTLE_CYCLES) settle <= settle + 1;
            else begin
               settle <= 0;
               op = stim_q.pop_front();
               if (op.kind == OP_SIDES) begin
                  wr = 1'b1;
                  csr_wr_data <= op.sides;
                  sides_reg = op.sides;
                  n_sides_writes++;
               end
               req_idle_on = $urandom_range(2) != 0;
               rsp_idle_on = $urandom_range(2) != 0;
            end
         end
      end
      csr_wr_en <= wr;
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      vertex_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_vertices++;
            if (vertex_q.size() == 0) begin
               $error("unexpected rsp beat: %h", rsp_tdata);
               errors++;
            end else begin
               e = vertex_q.pop_front();
               if (rsp_tdata[23:0] !== e.vx) begin
                  $error("vertex_x expected %h actual %h", e.vx, rsp_tdata[23:0]);
                  errors++;
               end
               if (rsp_tdata[47:24] !== e.vy) begin
                  $error("vertex_y expected %h actual %h", e.vy, rsp_tdata[47:24]);
                  errors++;
               end
               if (rsp_tdata[53:48] !== e.idx) begin
                  $error("vertex_index expected %0d actual %0d", e.idx, rsp_tdata[53:48]);
                  errors++;
               end
               if (rsp_tuser !== e.empty) begin
                  $error("empty_shape expected %b actual %b", e.empty, rsp_tuser);
                  errors++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("last_vertex expected %b actual %b", e.last, rsp_tlast);
                  errors++;
               end
            end
         end
         if (stall > 0) begin
            stall <= stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall <= pick_gap(rsp_idle_on);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) || csr_wr_en)
            watchdog <= 0;
         else if (watchdog >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
         end else
            watchdog <= watchdog + 1;
      end
   end

   task automatic add_drag(logic signed [CW-1:0] sx, sy, ex, ey, logic sq, fc);
      stim_type s;
      s = '{kind: OP_DRAG, sx: sx, sy: sy, ex: ex, ey: ey, sq: sq, fc: fc, sides: '0};
      stim_q.insert(stim_q.size(), s);
   endtask

   task automatic add_op(op_kind_type k, logic [6:0] v);
      stim_type s;
      s = '{kind: k, sx: '0, sy: '0, ex: '0, ey: '0, sq: 1'b0, fc: 1'b0, sides: v};
      stim_q.insert(stim_q.size(), s);
   endtask

   task automatic add_random_drag();
      logic signed [CW-1:0] sx, sy, ex, ey;
      logic signed [CW-1:0] pick[4];
      int r;
      pick = '{CMIN, CMAX, 24'sd0, -24'sd1};
      r = $urandom_range(99);
      sx = CW'($urandom);
      sy = CW'($urandom);
      if (r < 50) begin
         ex = sx + CW'($urandom_range(4000) - 2000);
         ey = sy + CW'($urandom_range(4000) - 2000);
      end else if (r < 70) begin
         ex = CW'($urandom);
         ey = CW'($urandom);
      end else if (r < 85) begin
         ex = $urandom_range(1) ? sx : CW'($urandom);
         ey = (ex == sx) ? CW'($urandom) : sy;
      end else begin
         sx = pick[2'($urandom_range(3))];
         sy = pick[2'($urandom_range(3))];
         ex = pick[2'($urandom_range(3))];
         ey = pick[2'($urandom_range(3))];
      end
      add_drag(sx, sy, ex, ey, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   initial begin
      int drags, len;
      logic [6:0] v;
      // reset side count first, then the corner cases
      add_drag(0, 0, 2560, 5120, 0, 0);
      add_drag(100, 100, 100, 100, 0, 0);
      add_drag(-700, 40, 900, 40, 0, 0);
      add_drag(0, 0, -300, 0, 1, 0);
      add_drag(0, 0, -500, 700, 0, 1);
      add_drag(-1000, 2000, -1300, 1900, 1, 1);
      add_drag(CMIN, CMIN, CMAX, CMAX, 0, 0);
      add_drag(CMAX, CMAX, CMIN, CMIN, 1, 1);
      add_drag(CMIN, CMAX, CMAX, CMIN, 0, 1);
      add_op(OP_SIDES, 7'd0);
      add_drag(256, -256, -4096, 8192, 0, 0);
      add_op(OP_SIDES, 7'd1);
      add_drag(256, -256, 4096, -8192, 1, 0);
      add_op(OP_SIDES, 7'd2);
      add_drag(-5, 7, 1000, 3, 0, 1);
      add_op(OP_SIDES, 7'd127);
      add_drag(0, 0, 65536, 32768, 0, 0);
      add_op(OP_SIDES, 7'd64);
      add_drag(CMIN, CMIN, CMAX, CMAX, 0, 1);
      add_op(OP_SIDES, 7'd65);
      add_drag(1000, 1000, 2000, 3000, 0, 0);
      add_op(OP_SIDES, 7'd3);
      add_drag(CMAX, CMIN, CMAX - 1, CMIN + 1, 0, 0);
      add_drag(12, 12, 12, 40, 1, 0);
      add_op(OP_SIDES, 7'd4);
      add_drag(-8000, 9000, 8000, -9000, 0, 1);
      drags = 18;
      while (drags < DRAG_TARGET) begin
         v = ($urandom_range(9) < 8) ? 7'($urandom_range(12)) : 7'($urandom_range(13, 127));
         len = (v > 16) ? $urandom_range(2, 4) : $urandom_range(15, 40);
         add_op(OP_SIDES, v);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(19) == 0) add_op(OP_QUIESCE, '0);
            add_random_drag();
         end
         drags += len;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (!(drv_done && vertex_q.size() == 0)) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("covered %0d drags, %0d vertex beats, %0d collapsed boxes, %0d side writes",
               n_drags, n_vertices, n_empty, n_sides_writes);
      if (errors == 0 && vertex_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dbpv_pkg.sv
rtl/dbpv_front.sv
rtl/dbpv_fifo.sv
rtl/dbpv_back.sv
rtl/drag_box_polygon_vertices.sv
rtl/dbpv_checker.sv
tb/sv/tb_drag_box_polygon_vertices.sv
